// ===== rtl/pli_pkg.sv =====
// Shared codes and types for the positional list insert/delete block.
package pli_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W = 7;
  localparam int ACT_W = 3;
  localparam int STAT_W = 2;
  localparam int CNT_OUT_W = 7;

  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_END = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_POS = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEL_END = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DEL_POS = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

  localparam logic [1:0] KIND_HOLD = 2'd0;
  localparam logic [1:0] KIND_INS = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       hit;
    logic       above;
  } pli_cell_ctrl_t;

endpackage

// ===== rtl/pli_cell.sv =====
// One list slot: holds an entry and shifts toward either neighbor on command.
module pli_cell (
  input  logic                          clk,
  input  pli_pkg::pli_cell_ctrl_t       ctrl,
  input  logic [pli_pkg::DATA_W-1:0]    value,
  input  logic [pli_pkg::DATA_W-1:0]    left,
  input  logic [pli_pkg::DATA_W-1:0]    right,
  output logic [pli_pkg::DATA_W-1:0]    entry,
  output logic [pli_pkg::DATA_W-1:0]    tap
);
  import pli_pkg::*;

  logic [DATA_W-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    case (ctrl.kind)
      KIND_INS: begin
        if (ctrl.hit) begin
          entry_next = value;
        end else if (ctrl.above) begin
          entry_next = left;
        end
      end
      KIND_DEL: begin
        if (ctrl.hit || ctrl.above) begin
          entry_next = right;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign tap = ctrl.hit ? entry : '0;

endmodule

// ===== rtl/positional_list_insert_delete.sv =====
// Top level of the positional list: request decode, cell chain and result register.
// The list holds up to CAPACITY signed 32-bit entries in a row of cells, slot 0 at the
// front; every successful operation shifts the cells above the chosen slot by one place at
// once, so one word can be taken on each cycle unless the output stalls, and its result word
// is presented from the cycle after it was taken. The input is held off while a result word
// waits on a receiver that is not ready, and a new word is taken in the same cycle that the
// waiting result word leaves. The rate is set by the shared slot decode feeding all cells
// at once. A failed request leaves the list unchanged and returns zero as the removed value.
module positional_list_insert_delete #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: value[31:0], position[38:32], zero fill.
  input  logic [39:0] s_tdata,
  // Fields from bit 0: action[2:0].
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: status[1:0], removed_value[33:2], entry_count[40:34], zero fill.
  output logic [47:0] m_tdata
);
  import pli_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [ACT_W-1:0]     action;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]     position;
  logic [XW-1:0]        cnt_x;
  logic [XW-1:0]        pos_x;
  logic                 full;
  logic                 empty;
  logic [STAT_W-1:0]    status_next;
  logic [1:0]           kind_req;
  logic [1:0]           kind;
  logic [IW-1:0]        slot;
  logic                 accept;
  logic [DATA_W-1:0]    got;
  logic [DATA_W-1:0]    removed_next;
  logic [STAT_W-1:0]    status;
  logic [DATA_W-1:0]    removed_value;
  logic [CNT_OUT_W-1:0] entry_count;
  logic [DATA_W-1:0]    entry [CAPACITY];
  logic [DATA_W-1:0]    tap [CAPACITY];
  pli_cell_ctrl_t       ctrl [CAPACITY];

  assign value = s_tdata[DATA_W-1:0];
  assign position = s_tdata[DATA_W+POS_W-1:DATA_W];
  assign action = s_tuser;

  assign s_tready = !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;

  assign cnt_x = XW'(count);
  assign pos_x = XW'(position);
  assign full = (cnt_x >= XW'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    status_next = ST_OK;
    kind_req = KIND_HOLD;
    slot = '0;
    unique case (action)
      ACT_INS_FRONT: begin
        kind_req = KIND_INS;
        status_next = full ? ST_FULL : ST_OK;
      end
      ACT_INS_END: begin
        kind_req = KIND_INS;
        slot = IW'(cnt_x);
        status_next = full ? ST_FULL : ST_OK;
      end
      ACT_INS_POS: begin
        kind_req = KIND_INS;
        slot = IW'(pos_x - XW'(1));
        if (full) begin
          status_next = ST_FULL;
        end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
          status_next = ST_RANGE;
        end
      end
      ACT_DEL_FRONT: begin
        kind_req = KIND_DEL;
        status_next = empty ? ST_EMPTY : ST_OK;
      end
      ACT_DEL_END: begin
        kind_req = KIND_DEL;
        slot = IW'(cnt_x - XW'(1));
        status_next = empty ? ST_EMPTY : ST_OK;
      end
      ACT_DEL_POS: begin
        kind_req = KIND_DEL;
        slot = IW'(pos_x - XW'(1));
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          status_next = ST_RANGE;
        end
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  assign kind = (accept && status_next == ST_OK) ? kind_req : KIND_HOLD;

  always_comb begin
    count_next = count;
    if (status_next == ST_OK && kind_req == KIND_INS) begin
      count_next = count + CW'(1);
    end else if (status_next == ST_OK && kind_req == KIND_DEL) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;

    assign ctrl[i].kind = kind;
    assign ctrl[i].hit = (slot == IW'(i));
    assign ctrl[i].above = (slot < IW'(i));

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = entry[i+1];
    end

    pli_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl[i]),
      .value (value),
      .left  (left),
      .right (right),
      .entry (entry[i]),
      .tap   (tap[i])
    );
  end

  always_comb begin
    got = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      got = got | tap[i];
    end
  end

  assign removed_next = (status_next == ST_OK && kind_req == KIND_DEL) ? got : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      removed_value <= removed_next;
      entry_count <= CNT_OUT_W'(count_next);
    end
  end

  assign m_tdata = {7'd0, entry_count, removed_value, status};

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) XW'(count) <= XW'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    (accept && status_next == ST_OK && kind_req == KIND_INS) |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the list");

  assert property (@(posedge clk) disable iff (rst) !accept |=> $stable(count))
    else $error("count changed without a word");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != ST_OK) |-> removed_value == '0)
    else $error("failed request returned a value");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !accept) |=> !m_tvalid)
    else $error("result word repeated");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the positional list insert/delete block.
`timescale 1ns / 100ps

module testbench;
  import pli_pkg::*;

  localparam int CAP = 64;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [DATA_W-1:0]    removed;
    logic [CNT_OUT_W-1:0] count;
  } list_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  logic [DATA_W-1:0] list_q[$];
  list_result_t      pending_results[$];

  bit src_idle;
  bit sink_idle;
  int hold_cycles;
  int err_cnt;
  int words_in;
  int words_out;
  int status_seen[4];

  positional_list_insert_delete #(.CAPACITY(CAP)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("testbench: done, errors");
    $finish;
  end

  function automatic list_result_t list_apply(logic [ACT_W-1:0] act, logic [DATA_W-1:0] v,
                                              logic [POS_W-1:0] pos);
    list_result_t r;
    int n;
    int slot;
    r.status = ST_OK;
    r.removed = '0;
    n = list_q.size();
    case (act)
      ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
        if (n >= CAP) begin
          r.status = ST_FULL;
        end else if (act == ACT_INS_POS && (pos == 0 || int'(pos) > n + 1)) begin
          r.status = ST_RANGE;
        end else begin
          slot = (act == ACT_INS_FRONT) ? 0 : (act == ACT_INS_END) ? n : int'(pos) - 1;
          list_q.insert(slot, v);
        end
      end
      ACT_DEL_FRONT, ACT_DEL_END, ACT_DEL_POS: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else if (act == ACT_DEL_POS && (pos == 0 || int'(pos) > n)) begin
          r.status = ST_RANGE;
        end else begin
          slot = (act == ACT_DEL_FRONT) ? 0 : (act == ACT_DEL_END) ? n - 1 : int'(pos) - 1;
          r.removed = list_q[slot];
          list_q.delete(slot);
        end
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    r.count = CNT_OUT_W'(list_q.size());
    status_seen[r.status]++;
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the word was taken.
  task automatic push_request(logic [ACT_W-1:0] act, logic [DATA_W-1:0] v,
                              logic [POS_W-1:0] pos);
    int gap;
    gap = src_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, pos, v};
    s_tuser <= act;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(list_apply(act, v, pos));
    words_in++;
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(bit for_insert);
    int lim;
    lim = for_insert ? list_q.size() + 1 : list_q.size();
    if (lim >= 1 && $urandom_range(0, 99) < 80) return POS_W'($urandom_range(1, lim));
    return POS_W'($urandom_range(0, 127));
  endfunction

  task automatic random_op(bit grow);
    logic [ACT_W-1:0] act;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      act = ($urandom_range(0, 1) == 0) ? 3'd6 : 3'd7;
    end else if ($urandom_range(0, 99) < (grow ? 70 : 30)) begin
      act = ACT_W'($urandom_range(0, 2));
    end else begin
      act = ACT_W'($urandom_range(3, 5));
    end
    push_request(act, pick_value(), pick_pos(act <= ACT_INS_POS));
  endtask

  task automatic test_directed();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    push_request(ACT_DEL_FRONT, 32'h1111_1111, 7'd1);
    push_request(ACT_DEL_END, 32'h0, 7'd0);
    push_request(ACT_DEL_POS, 32'h0, 7'd0);
    push_request(ACT_INS_POS, 32'h5555_5555, 7'd0);
    push_request(ACT_INS_POS, 32'h5555_5555, 7'd2);
    push_request(ACT_INS_POS, 32'h7FFF_FFFF, 7'd1);
    push_request(ACT_INS_FRONT, 32'h8000_0000, 7'd127);
    push_request(ACT_INS_END, 32'h0000_0000, 7'd0);
    push_request(ACT_INS_END, 32'hFFFF_FFFF, 7'd0);
    push_request(ACT_INS_POS, 32'h1234_5678, 7'd5);
    push_request(ACT_INS_POS, 32'hA5A5_A5A5, 7'd3);
    push_request(ACT_INS_POS, 32'h5A5A_5A5A, 7'd127);
    push_request(ACT_DEL_POS, 32'h0, 7'd0);
    push_request(ACT_DEL_POS, 32'h0, 7'd7);
    push_request(ACT_DEL_POS, 32'hFFFF_FFFF, 7'd127);
    push_request(3'd6, 32'hDEAD_BEEF, 7'd1);
    push_request(3'd7, 32'hFFFF_FFFF, 7'd127);
    push_request(ACT_DEL_POS, 32'h0, 7'd6);
    push_request(ACT_DEL_POS, 32'h0, 7'd2);
    push_request(ACT_DEL_FRONT, 32'h0, 7'd0);
    push_request(ACT_DEL_END, 32'h0, 7'd0);
    push_request(ACT_DEL_POS, 32'h0, 7'd1);
    push_request(ACT_DEL_END, 32'h0, 7'd0);
    push_request(ACT_DEL_END, 32'h0, 7'd0);
    wait_for_results();
  endtask

  task automatic test_full_list();
    src_idle = 1'b0;
    sink_idle = 1'b1;
    while (list_q.size() < CAP) begin
      push_request(ACT_W'($urandom_range(0, 2)), pick_value(),
                   POS_W'($urandom_range(1, list_q.size() + 1)));
    end
    push_request(ACT_INS_FRONT, 32'h0, 7'd0);
    push_request(ACT_INS_END, 32'h7FFF_FFFF, 7'd0);
    push_request(ACT_INS_POS, 32'h1, 7'd0);
    push_request(ACT_INS_POS, 32'h1, 7'd65);
    push_request(ACT_INS_POS, 32'h1, 7'd1);
    push_request(ACT_DEL_POS, 32'h0, 7'd65);
    push_request(ACT_DEL_POS, 32'h0, 7'd64);
    push_request(ACT_INS_POS, 32'h8000_0000, 7'd64);
    src_idle = 1'b1;
    while (list_q.size() > 0) begin
      push_request(ACT_W'($urandom_range(3, 5)), pick_value(),
                   POS_W'($urandom_range(1, list_q.size())));
    end
    push_request(ACT_DEL_POS, 32'h0, 7'd1);
    push_request(ACT_DEL_FRONT, 32'h0, 7'd0);
    wait_for_results();
  endtask

  task automatic test_output_stall();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    hold_cycles = 200;
    repeat (40) random_op(1'b1);
    wait_for_results();
  endtask

  task automatic test_random_ops(int n_items);
    bit grow;
    grow = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        src_idle = ($urandom_range(0, 2) != 0);
        sink_idle = ($urandom_range(0, 2) != 0);
      end
      if (i == n_items / 2) wait_for_results();
      if (list_q.size() >= CAP) grow = 1'b0;
      else if (list_q.size() == 0) grow = 1'b1;
      else if ($urandom_range(0, 149) == 0) grow = ~grow;
      random_op(grow);
    end
    wait_for_results();
  endtask

  // Result side: random stalls, an optional long hold-off, and the field checks.
  initial begin
    list_result_t exp_r;
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = sink_idle ? $urandom_range(0, 12) : 0;
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      words_out++;
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[1:0] !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, m_tdata[1:0]);
          err_cnt++;
        end
        if (m_tdata[33:2] !== exp_r.removed) begin
          $error("removed_value: expected %h, got %h", exp_r.removed, m_tdata[33:2]);
          err_cnt++;
        end
        if (m_tdata[40:34] !== exp_r.count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.count, m_tdata[40:34]);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    hold_cycles = 0;
    err_cnt = 0;
    words_in = 0;
    words_out = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_list();
    test_output_stall();
    test_random_ops(1700);
    s_tvalid <= 1'b0;
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_cnt++;
    end
    $display("testbench: %0d words in, %0d results checked", words_in, words_out);
    $display("testbench: status mix ok %0d, empty %0d, range %0d, full %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
             status_seen[ST_FULL]);
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pli_pkg.sv
rtl/pli_cell.sv
rtl/positional_list_insert_delete.sv
dv/testbench.sv
